@@ hw/rtl/scms_pkg.sv @@
package scms_pkg;

	localparam int CHANNEL_COUNT = 1024;
	localparam int NUM_STATES    = 8;
	localparam int STATE_W       = 3;
	localparam int SLOTS         = 3;
	localparam int RATE_W        = 16;
	localparam int OUT_W         = 11;
	// internal count width: holds CHANNEL_COUNT, never narrower than the result fields
	localparam int CNT_W = ($clog2(CHANNEL_COUNT + 1) > OUT_W) ?
		$clog2(CHANNEL_COUNT + 1) : OUT_W;
	localparam int SCALED_W = RATE_W + 2;
	localparam int THR_W    = RATE_W + 3;

	typedef enum logic [1:0] {
		REG_ALPHA_M = 2'd0,
		REG_BETA_M  = 2'd1,
		REG_ALPHA_H = 2'd2,
		REG_BETA_H  = 2'd3
	} rate_sel_t;

	typedef struct packed {
		logic [STATE_W-1:0] target;
		rate_sel_t          sel;
		logic [1:0]         mult;   // 0: no move in this slot
	} move_t;

	// neighbour moves per state, in threshold order
	localparam move_t MOVE_TABLE [NUM_STATES][SLOTS] = '{
		'{ '{3'd1, REG_ALPHA_M, 2'd3}, '{3'd4, REG_BETA_H,  2'd1}, '{3'd0, REG_ALPHA_M, 2'd0} },
		'{ '{3'd2, REG_ALPHA_M, 2'd2}, '{3'd5, REG_BETA_H,  2'd1}, '{3'd0, REG_BETA_M,  2'd1} },
		'{ '{3'd3, REG_ALPHA_M, 2'd1}, '{3'd6, REG_BETA_H,  2'd1}, '{3'd1, REG_BETA_M,  2'd2} },
		'{ '{3'd2, REG_BETA_M,  2'd3}, '{3'd7, REG_BETA_H,  2'd1}, '{3'd0, REG_ALPHA_M, 2'd0} },
		'{ '{3'd5, REG_ALPHA_M, 2'd3}, '{3'd0, REG_ALPHA_H, 2'd1}, '{3'd0, REG_ALPHA_M, 2'd0} },
		'{ '{3'd6, REG_ALPHA_M, 2'd2}, '{3'd1, REG_ALPHA_H, 2'd1}, '{3'd4, REG_BETA_M,  2'd1} },
		'{ '{3'd7, REG_ALPHA_M, 2'd1}, '{3'd2, REG_ALPHA_H, 2'd1}, '{3'd5, REG_BETA_M,  2'd2} },
		'{ '{3'd6, REG_BETA_M,  2'd3}, '{3'd3, REG_ALPHA_H, 2'd1}, '{3'd0, REG_ALPHA_M, 2'd0} }
	};

	// rate times 0..3 by shift and add
	function automatic logic [SCALED_W-1:0] scale_rate(input logic [RATE_W-1:0] rate,
		input logic [1:0] mult);
		logic [SCALED_W-1:0] twice;
		logic [SCALED_W-1:0] once;
		twice = mult[1] ? {1'b0, rate, 1'b0} : '0;
		once  = mult[0] ? {2'b00, rate} : '0;
		return twice + once;
	endfunction

	// lowest set bit at or above start; {found, index}
	function automatic logic [STATE_W:0] first_from(input logic [NUM_STATES-1:0] mask,
		input logic [STATE_W:0] start);
		logic [STATE_W:0] res;
		res = '0;
		for (int i = NUM_STATES - 1; i >= 0; i--) begin
			if (mask[i] && (STATE_W'(i) >= start[STATE_W-1:0]) && !start[STATE_W]) begin
				res = {1'b1, STATE_W'(i)};
			end
		end
		return res;
	endfunction

endpackage

@@ hw/rtl/sodium_channel_markov_sweep_top.sv @@
// A draw in the draw register has its result loaded into the count registers (the ports)
// when it advances. Throughput: one draw per cycle unless result_ready stalls; the whole
//   channel update (threshold adds, compare, count move, sweep walk) sits between those registers.
// Reset (arst_n low, asynchronous): all channels in m0h1, rates zero, no sweep running,
//   both stages empty. No clearing pass; a draw can be taken from the first cycle out of reset.
module sodium_channel_markov_sweep_top (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [1:0]                  cfg_index,
	input  logic [scms_pkg::RATE_W-1:0] cfg_data,
	input  logic                        draw_valid,
	output logic                        draw_ready,
	input  logic [scms_pkg::RATE_W-1:0] random_fraction,
	output logic                        result_valid,
	input  logic                        result_ready,
	output logic [scms_pkg::OUT_W-1:0]  count_m0_h1,
	output logic [scms_pkg::OUT_W-1:0]  count_m1_h1,
	output logic [scms_pkg::OUT_W-1:0]  count_m2_h1,
	output logic [scms_pkg::OUT_W-1:0]  count_m3_h1,
	output logic [scms_pkg::OUT_W-1:0]  count_m0_h0,
	output logic [scms_pkg::OUT_W-1:0]  count_m1_h0,
	output logic [scms_pkg::OUT_W-1:0]  count_m2_h0,
	output logic [scms_pkg::OUT_W-1:0]  count_m3_h0,
	output logic                        sweep_done
);
	import scms_pkg::*;

	// rate registers, Q0.16
	logic [RATE_W-1:0] alpha_m_q, beta_m_q, alpha_h_q, beta_h_q;

	// draw register (stage 1)
	logic              valid_s1;
	logic [RATE_W-1:0] draw_s1;

	// population and sweep walk
	logic [CNT_W-1:0]   counts_q   [NUM_STATES];
	logic [CNT_W-1:0]   snapshot_q [NUM_STATES];
	logic [STATE_W-1:0] walk_state_q;
	logic [CNT_W-1:0]   walk_index_q;
	logic               sweep_active_q;

	// result register: counts are shown straight from counts_q, which only
	// change when a new result is loaded
	logic result_valid_q;
	logic done_q;

	logic advance;

	// update path
	logic [CNT_W-1:0]      snap_eff [NUM_STATES];
	logic [NUM_STATES-1:0] nz_live, nz_snap, nz_eff;
	logic [STATE_W-1:0]    ws;
	logic [CNT_W-1:0]      wi;
	logic [STATE_W:0]      first_hit;
	logic                  act;
	logic [THR_W-1:0]      thr;
	logic                  hit, stop;
	logic [STATE_W-1:0]    tgt;
	move_t                 mv;
	logic [RATE_W-1:0]     rate_pick;
	logic                  move_en;
	logic [CNT_W:0]        wi_inc;
	logic [NUM_STATES-1:0] last_vec;
	logic [STATE_W:0]      next_hit;
	logic [CNT_W-1:0]      counts_d [NUM_STATES];
	logic [CNT_W+2:0]      count_total;

	//------------------------------------------------------------------
	// Handshake: stage 1 moves into the result register when that is free
	// or being emptied in the same cycle.
	//------------------------------------------------------------------
	assign advance      = valid_s1 && (!result_valid_q || result_ready);
	assign draw_ready   = !valid_s1 || advance;
	assign result_valid = result_valid_q;
	assign sweep_done   = done_q;

	assign count_m0_h1 = counts_q[0][OUT_W-1:0];
	assign count_m1_h1 = counts_q[1][OUT_W-1:0];
	assign count_m2_h1 = counts_q[2][OUT_W-1:0];
	assign count_m3_h1 = counts_q[3][OUT_W-1:0];
	assign count_m0_h0 = counts_q[4][OUT_W-1:0];
	assign count_m1_h0 = counts_q[5][OUT_W-1:0];
	assign count_m2_h0 = counts_q[6][OUT_W-1:0];
	assign count_m3_h0 = counts_q[7][OUT_W-1:0];

	//------------------------------------------------------------------
	// Configuration writes
	//------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_m_q <= '0;
			beta_m_q  <= '0;
			alpha_h_q <= '0;
			beta_h_q  <= '0;
		end else if (cfg_we) begin
			unique case (rate_sel_t'(cfg_index))
				REG_ALPHA_M: alpha_m_q <= cfg_data;
				REG_BETA_M:  beta_m_q  <= cfg_data;
				REG_ALPHA_H: alpha_h_q <= cfg_data;
				REG_BETA_H:  beta_h_q  <= cfg_data;
				default:     ;
			endcase
		end
	end

	//------------------------------------------------------------------
	// Channel update for the draw in stage 1
	//------------------------------------------------------------------
	always_comb begin
		for (int i = 0; i < NUM_STATES; i++) begin
			nz_live[i] = (counts_q[i] != '0);
			nz_snap[i] = (snapshot_q[i] != '0);
		end

		// a new sweep starts from a snapshot of the live counts
		first_hit = first_from(nz_live, '0);
		if (sweep_active_q) begin
			for (int i = 0; i < NUM_STATES; i++) snap_eff[i] = snapshot_q[i];
			nz_eff = nz_snap;
			ws     = walk_state_q;
			wi     = walk_index_q;
		end else begin
			for (int i = 0; i < NUM_STATES; i++) snap_eff[i] = counts_q[i];
			nz_eff = nz_live;
			ws     = first_hit[STATE_W-1:0];
			wi     = '0;
		end
		act = sweep_active_q || (|nz_live);

		// cumulative thresholds, first capture wins
		thr       = '0;
		hit       = 1'b0;
		stop      = 1'b0;
		tgt       = '0;
		mv        = MOVE_TABLE[0][0];
		rate_pick = '0;
		for (int k = 0; k < SLOTS; k++) begin
			mv = MOVE_TABLE[ws][k];
			unique case (mv.sel)
				REG_ALPHA_M: rate_pick = alpha_m_q;
				REG_BETA_M:  rate_pick = beta_m_q;
				REG_ALPHA_H: rate_pick = alpha_h_q;
				REG_BETA_H:  rate_pick = beta_h_q;
				default:     rate_pick = '0;
			endcase
			if (!hit && !stop) begin
				if (mv.mult == 2'd0) begin
					stop = 1'b1;
				end else begin
					thr = thr + THR_W'(scale_rate(rate_pick, mv.mult));
					if ({{(THR_W-RATE_W){1'b0}}, draw_s1} <= thr) begin
						hit = 1'b1;
						tgt = mv.target;
					end
				end
			end
		end
		move_en = act && hit && nz_live[ws];

		for (int i = 0; i < NUM_STATES; i++) begin
			counts_d[i] = counts_q[i];
			if (move_en && (STATE_W'(i) == ws))  counts_d[i] = counts_d[i] - 1'b1;
			if (move_en && (STATE_W'(i) == tgt)) counts_d[i] = counts_d[i] + 1'b1;
		end

		// walk bookkeeping
		wi_inc = {1'b0, wi} + 1'b1;
		for (int i = 0; i < NUM_STATES; i++) last_vec[i] = (wi_inc >= {1'b0, snap_eff[i]});
		next_hit = first_from(nz_eff, {1'b0, ws} + 1'b1);

		count_total = '0;
		for (int i = 0; i < NUM_STATES; i++) count_total = count_total + (CNT_W+3)'(counts_q[i]);
	end

	//------------------------------------------------------------------
	// Stage 1 and state/result registers
	//------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1       <= 1'b0;
			result_valid_q <= 1'b0;
			done_q         <= 1'b0;
			sweep_active_q <= 1'b0;
			walk_state_q   <= '0;
			walk_index_q   <= '0;
			for (int i = 0; i < NUM_STATES; i++) begin
				counts_q[i]   <= (i == 0) ? CNT_W'(CHANNEL_COUNT) : '0;
				snapshot_q[i] <= '0;
			end
		end else begin
			if (draw_ready) valid_s1 <= draw_valid;

			if (advance) begin
				result_valid_q <= 1'b1;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end

			if (advance) begin
				for (int i = 0; i < NUM_STATES; i++) counts_q[i] <= counts_d[i];
				if (!sweep_active_q) begin
					for (int i = 0; i < NUM_STATES; i++) snapshot_q[i] <= counts_q[i];
				end
				priority if (!act) begin
					// nothing to visit: an empty draw ends at once
					done_q         <= 1'b1;
					sweep_active_q <= 1'b0;
					walk_state_q   <= '0;
					walk_index_q   <= '0;
				end else if (last_vec[ws]) begin
					walk_index_q   <= '0;
					walk_state_q   <= next_hit[STATE_W] ? next_hit[STATE_W-1:0] : '0;
					sweep_active_q <= next_hit[STATE_W];
					done_q         <= !next_hit[STATE_W];
				end else begin
					walk_index_q   <= wi_inc[CNT_W-1:0];
					walk_state_q   <= ws;
					sweep_active_q <= 1'b1;
					done_q         <= 1'b0;
				end
			end
		end
	end

	// draw register is payload only
	always_ff @(posedge clk) begin
		if (draw_ready && draw_valid) draw_s1 <= random_fraction;
	end

	//------------------------------------------------------------------
	// Checks
	//------------------------------------------------------------------
	a_population_kept: assert property (@(posedge clk) disable iff (!arst_n)
		count_total == (CNT_W+3)'(CHANNEL_COUNT))
		else $error("channel population not conserved");

	a_walk_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		sweep_active_q |-> (walk_index_q < snapshot_q[walk_state_q]))
		else $error("walk index beyond snapshot count");

	a_idle_walk_clear: assert property (@(posedge clk) disable iff (!arst_n)
		!sweep_active_q |-> (walk_state_q == '0 && walk_index_q == '0))
		else $error("walk position left over after sweep");

	a_advance_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> result_valid_q)
		else $error("processed draw produced no result");

endmodule
